// ----- sv/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Feeder and flywheel shot controller package
// Shared widths, constants, register indexes and types for the controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Word field widths.
  localparam int EnableW  = 4;
  localparam int ErrorW   = 16;
  localparam int SpeedW   = 16;
  localparam int DriveW   = 17;
  localparam int RefW     = 16;
  localparam int GateW    = 10;
  localparam int WheelW   = 12;
  localparam int RateW    = 15;
  localparam int GainW    = 16;
  localparam int LimitW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int JamCntW  = 8;

  // Internal PID widths.
  localparam int ErrW     = 18;
  localparam int DerrW    = 19;
  localparam int AccW     = 38;

  // Enable bit positions.
  localparam int EnWheels = 0;
  localparam int EnHeat   = 1;
  localparam int EnForce  = 2;
  localparam int EnCheck  = 3;

  // Behavioural constants.
  localparam logic [JamCntW-1:0]      JamTicks  = 8'd30;
  localparam logic [JamCntW-1:0]      JamHold   = 8'd200;
  localparam logic signed [RefW-1:0]  RefJam    = -16'sd1000;
  localparam logic signed [RefW-1:0]  RefFast   = 16'sd2000;
  localparam logic signed [RefW-1:0]  RefSlow   = 16'sd1000;
  localparam logic signed [SpeedW-1:0] SlowSpeed = 16'sd10;
  localparam logic signed [ErrorW-1:0] AimWindow = 16'sd640;
  localparam logic [GateW-1:0]        GateOpen  = 10'd1000;
  localparam logic [GateW-1:0]        GateShut  = 10'd500;
  localparam logic [WheelW-1:0]       WheelStep = 12'd5;
  localparam logic [WheelW-1:0]       WheelIdle = 12'd1000;
  localparam logic [WheelW-1:0]       WheelRst  = 12'd999;

  // Register reset values.
  localparam logic [RateW-1:0]  FireRateRst    = 15'd3000;
  localparam logic [RateW-1:0]  CheckRateRst   = 15'd600;
  localparam logic [WheelW-1:0] WheelTargetRst = 12'd1300;
  localparam logic [GainW-1:0]  GainPRst       = 16'd3328;
  localparam logic [GainW-1:0]  GainIRst       = 16'd205;
  localparam logic [GainW-1:0]  GainDRst       = 16'd0;
  localparam logic [LimitW-1:0] SumLimitRst    = 16'd10000;
  localparam logic [LimitW-1:0] DriveLimitRst  = 16'd10000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRE_RATE    = 3'd0,
    CFG_CHECK_RATE   = 3'd1,
    CFG_WHEEL_TARGET = 3'd2,
    CFG_GAIN_P       = 3'd3,
    CFG_GAIN_I       = 3'd4,
    CFG_GAIN_D       = 3'd5,
    CFG_SUM_LIMIT    = 3'd6,
    CFG_DRIVE_LIMIT  = 3'd7
  } cfg_index_t;

  // Result fields that ride along the PID stages unchanged.
  typedef struct packed {
    logic signed [RefW-1:0] feed_reference;
    logic [GateW-1:0]       gate_pulse;
    logic [WheelW-1:0]      left_wheel_pwm;
    logic [WheelW-1:0]      right_wheel_pwm;
    logic                   jammed;
    logic                   firing;
  } tick_info_t;

endpackage

// ----- sv/fsc_if.sv -----
// ----------------------------------------------------------------------------
// Feeder and flywheel shot controller channels
// Valid/ready interfaces for the tick input, the result and register writes.
// ----------------------------------------------------------------------------

// Input tick word.
interface fsc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [fsc_pkg::EnableW-1:0]           enable_bits;
  logic                                  aim_auto;
  logic                                  target_captured;
  logic signed [fsc_pkg::ErrorW-1:0]     yaw_error;
  logic signed [fsc_pkg::ErrorW-1:0]     pitch_error;
  logic signed [fsc_pkg::SpeedW-1:0]     feed_speed;

  modport source (output valid, enable_bits, aim_auto, target_captured, yaw_error,
                  pitch_error, feed_speed, input ready);
  modport sink   (input valid, enable_bits, aim_auto, target_captured, yaw_error,
                  pitch_error, feed_speed, output ready);
endinterface

// Result word.
interface fsc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fsc_pkg::DriveW-1:0]     feed_drive;
  logic signed [fsc_pkg::RefW-1:0]       feed_reference;
  logic [fsc_pkg::GateW-1:0]             gate_pulse;
  logic [fsc_pkg::WheelW-1:0]            left_wheel_pwm;
  logic [fsc_pkg::WheelW-1:0]            right_wheel_pwm;
  logic                                  jammed;
  logic                                  firing;

  modport source (output valid, feed_drive, feed_reference, gate_pulse, left_wheel_pwm,
                  right_wheel_pwm, jammed, firing, input ready);
  modport sink   (input valid, feed_drive, feed_reference, gate_pulse, left_wheel_pwm,
                  right_wheel_pwm, jammed, firing, output ready);
endinterface

// Register write word.
interface fsc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [fsc_pkg::CfgIdxW-1:0]           index;
  logic [fsc_pkg::CfgDataW-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/feeder_flywheel_shot_controller.sv -----
// Throughput: one tick word per cycle while the result channel is not stalled;
// the controller state (jam detector, fire mode, error sum, flywheel ramps) is
// updated as each tick word leaves the first stage. The three gain multipliers
// work in parallel in the third stage.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers and controller state to their reset values.
// ----------------------------------------------------------------------------
// Feeder and flywheel shot controller
// Jam detection, fire mode selection, feeder velocity PID and flywheel ramps.
// ----------------------------------------------------------------------------
module feeder_flywheel_shot_controller (
  input  logic       clk,
  input  logic       rst_n,
  fsc_in_if.sink     in_chan,
  fsc_out_if.source  out_chan,
  fsc_cfg_if.sink    cfg_chan
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [fsc_pkg::RateW-1:0]  fire_rate_r, check_rate_r;
  logic [fsc_pkg::WheelW-1:0] wheel_target_r;
  logic [fsc_pkg::GainW-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [fsc_pkg::LimitW-1:0] sum_limit_r, drive_limit_r;

  assign cfg_chan.ready = 1'b1;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_rate_r    <= fsc_pkg::FireRateRst;
      check_rate_r   <= fsc_pkg::CheckRateRst;
      wheel_target_r <= fsc_pkg::WheelTargetRst;
      gain_p_r       <= fsc_pkg::GainPRst;
      gain_i_r       <= fsc_pkg::GainIRst;
      gain_d_r       <= fsc_pkg::GainDRst;
      sum_limit_r    <= fsc_pkg::SumLimitRst;
      drive_limit_r  <= fsc_pkg::DriveLimitRst;
    end else if (cfg_chan.valid) begin
      case (fsc_pkg::cfg_index_t'(cfg_chan.index))
        fsc_pkg::CFG_FIRE_RATE:    fire_rate_r    <= cfg_chan.data[fsc_pkg::RateW-1:0];
        fsc_pkg::CFG_CHECK_RATE:   check_rate_r   <= cfg_chan.data[fsc_pkg::RateW-1:0];
        fsc_pkg::CFG_WHEEL_TARGET: wheel_target_r <= cfg_chan.data[fsc_pkg::WheelW-1:0];
        fsc_pkg::CFG_GAIN_P:       gain_p_r       <= cfg_chan.data;
        fsc_pkg::CFG_GAIN_I:       gain_i_r       <= cfg_chan.data;
        fsc_pkg::CFG_GAIN_D:       gain_d_r       <= cfg_chan.data;
        fsc_pkg::CFG_SUM_LIMIT:    sum_limit_r    <= cfg_chan.data;
        fsc_pkg::CFG_DRIVE_LIMIT:  drive_limit_r  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic s1_move, s2_move, s3_move;

  // Each stage may load when it is empty or its contents move on.
  assign s4_ready = !s4_valid_r || out_chan.ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_chan.ready = s1_ready;

  assign s1_move = s1_valid_r && s2_ready;
  assign s2_move = s2_valid_r && s3_ready;
  assign s3_move = s3_valid_r && s4_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_chan.valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic [fsc_pkg::EnableW-1:0]       en_r;
  logic                              aim_r, cap_r;
  logic signed [fsc_pkg::ErrorW-1:0] yaw_r, pitch_r;
  logic signed [fsc_pkg::SpeedW-1:0] speed_r;

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      en_r    <= in_chan.enable_bits;
      aim_r   <= in_chan.aim_auto;
      cap_r   <= in_chan.target_captured;
      yaw_r   <= in_chan.yaw_error;
      pitch_r <= in_chan.pitch_error;
      speed_r <= in_chan.feed_speed;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [fsc_pkg::WheelW-1:0]        left_r, right_r, left_nxt, right_nxt;
  logic [fsc_pkg::JamCntW-1:0]       jam_cnt_r, jam_cnt_nxt;
  logic                              jam_r, jam_nxt;
  logic                              mode_prev_r, series;
  logic signed [fsc_pkg::RefW-1:0]   ref_prev_r, ref_nxt;
  logic [fsc_pkg::GateW-1:0]         gate_r, gate_nxt;
  logic signed [fsc_pkg::ErrW-1:0]   sum_r, sum_nxt, err_prev_r, err;
  logic signed [fsc_pkg::DerrW-1:0]  derr;

  // Jam detector, using the previous tick's fire mode and reference.
  logic [fsc_pkg::JamCntW-1:0] cnt_inc;
  logic                        slow_feed;

  always_comb begin
    cnt_inc     = jam_cnt_r + 8'd1;
    jam_cnt_nxt = jam_cnt_r;
    jam_nxt     = jam_r;
    slow_feed   = mode_prev_r && (ref_prev_r == fsc_pkg::RefFast ||
                  ref_prev_r == fsc_pkg::RefSlow) && speed_r <= fsc_pkg::SlowSpeed;
    if (slow_feed) begin
      if (cnt_inc >= fsc_pkg::JamTicks) begin
        jam_nxt     = 1'b1;
        jam_cnt_nxt = fsc_pkg::JamHold;
      end else begin
        jam_nxt     = 1'b0;
        jam_cnt_nxt = cnt_inc;
      end
    end else if (ref_prev_r != fsc_pkg::RefJam) begin
      jam_cnt_nxt = '0;
      jam_nxt     = 1'b0;
    end
    // Reversal countdown while the feeder is turning backwards.
    if (ref_prev_r < 0 && speed_r <= 0 && jam_nxt) begin
      jam_cnt_nxt = jam_cnt_nxt - 8'd1;
      if (jam_cnt_nxt == '0) jam_nxt = 1'b0;
    end
  end

  // Fire mode, feeder reference and gate.
  always_comb begin
    series = (aim_r && right_r == wheel_target_r && cap_r &&
              yaw_r > -fsc_pkg::AimWindow && yaw_r < fsc_pkg::AimWindow &&
              pitch_r > -fsc_pkg::AimWindow && pitch_r < fsc_pkg::AimWindow) ||
             en_r[fsc_pkg::EnForce];
    gate_nxt = gate_r;
    ref_nxt  = '0;
    if (!series) begin
      gate_nxt = fsc_pkg::GateShut;
    end else if (en_r[fsc_pkg::EnHeat]) begin
      gate_nxt = fsc_pkg::GateOpen;
      ref_nxt  = en_r[fsc_pkg::EnCheck] ? $signed({1'b0, check_rate_r})
                                        : $signed({1'b0, fire_rate_r});
    end
    if (jam_nxt) ref_nxt = fsc_pkg::RefJam;
  end

  // Error, clamped error sum and error difference.
  logic signed [fsc_pkg::ErrW:0] sum_raw, sum_hi, slim;

  always_comb begin
    err     = fsc_pkg::ErrW'(ref_nxt) - fsc_pkg::ErrW'(speed_r);
    slim    = $signed({3'b000, sum_limit_r});
    sum_raw = fsc_pkg::DerrW'(sum_r) + fsc_pkg::DerrW'(err);
    sum_hi  = (sum_raw >= slim) ? slim : sum_raw;
    if (sum_hi <= -slim) sum_hi = -slim;
    sum_nxt = sum_hi[fsc_pkg::ErrW-1:0];
    derr    = fsc_pkg::DerrW'(err) - fsc_pkg::DerrW'(err_prev_r);
  end

  // Flywheel ramps: the right wheel follows once the left wheel is at target.
  logic [fsc_pkg::WheelW:0] tgt_ext, left_sum, right_sum;

  always_comb begin
    tgt_ext   = {1'b0, wheel_target_r};
    left_sum  = {1'b0, left_r} + {1'b0, fsc_pkg::WheelStep};
    right_sum = {1'b0, right_r} + {1'b0, fsc_pkg::WheelStep};
    left_nxt  = fsc_pkg::WheelIdle;
    right_nxt = fsc_pkg::WheelIdle;
    if (en_r[fsc_pkg::EnWheels] || en_r[fsc_pkg::EnForce]) begin
      left_nxt  = (left_sum >= tgt_ext) ? wheel_target_r : left_sum[fsc_pkg::WheelW-1:0];
      right_nxt = right_r;
      if (left_nxt == wheel_target_r) begin
        right_nxt = (right_sum >= tgt_ext) ? wheel_target_r
                                           : right_sum[fsc_pkg::WheelW-1:0];
      end
    end
  end

  // State registers advance once per tick word, as it leaves stage 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= fsc_pkg::WheelRst;
      right_r     <= fsc_pkg::WheelRst;
      jam_cnt_r   <= '0;
      jam_r       <= 1'b0;
      mode_prev_r <= 1'b0;
      ref_prev_r  <= '0;
      gate_r      <= '0;
      sum_r       <= '0;
      err_prev_r  <= '0;
    end else if (s1_move) begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      jam_cnt_r   <= jam_cnt_nxt;
      jam_r       <= jam_nxt;
      mode_prev_r <= series;
      ref_prev_r  <= ref_nxt;
      gate_r      <= gate_nxt;
      sum_r       <= sum_nxt;
      err_prev_r  <= err;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: PID operands
  // --------------------------------------------------------------------------
  fsc_pkg::tick_info_t              s2_info_r;
  logic signed [fsc_pkg::ErrW-1:0]  s2_err_r, s2_sum_r;
  logic signed [fsc_pkg::DerrW-1:0] s2_derr_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_info_r.feed_reference  <= ref_nxt;
      s2_info_r.gate_pulse      <= gate_nxt;
      s2_info_r.left_wheel_pwm  <= left_nxt;
      s2_info_r.right_wheel_pwm <= right_nxt;
      s2_info_r.jammed          <= jam_nxt;
      s2_info_r.firing          <= series;
      s2_err_r                  <= err;
      s2_sum_r                  <= sum_nxt;
      s2_derr_r                 <= derr;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: gain products
  // --------------------------------------------------------------------------
  localparam int ProdW  = fsc_pkg::GainW + 1 + fsc_pkg::ErrW;
  localparam int ProdDW = fsc_pkg::GainW + 1 + fsc_pkg::DerrW;

  fsc_pkg::tick_info_t         s3_info_r;
  logic signed [ProdW-1:0]     p_term_r, i_term_r;
  logic signed [ProdDW-1:0]    d_term_r;

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_info_r <= s2_info_r;
      p_term_r  <= $signed({1'b0, gain_p_r}) * s2_err_r;
      i_term_r  <= $signed({1'b0, gain_i_r}) * s2_sum_r;
      d_term_r  <= $signed({1'b0, gain_d_r}) * s2_derr_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum, floor shift by 8 and drive clamp into the result register
  // --------------------------------------------------------------------------
  localparam int ShW = fsc_pkg::AccW - 8;

  logic signed [fsc_pkg::AccW-1:0] acc;
  logic signed [ShW-1:0]           drv_sh, dlim, drv_clip;

  always_comb begin
    acc    = fsc_pkg::AccW'(p_term_r) + fsc_pkg::AccW'(i_term_r) + fsc_pkg::AccW'(d_term_r);
    drv_sh = acc[fsc_pkg::AccW-1:8];
    dlim   = $signed({{(ShW - fsc_pkg::LimitW){1'b0}}, drive_limit_r});
    drv_clip = drv_sh;
    if (drv_sh > dlim)  drv_clip = dlim;
    if (drv_sh < -dlim) drv_clip = -dlim;
  end

  fsc_pkg::tick_info_t               s4_info_r;
  logic signed [fsc_pkg::DriveW-1:0] s4_drive_r;

  always_ff @(posedge clk) begin
    if (s3_move) begin
      s4_info_r  <= s3_info_r;
      s4_drive_r <= drv_clip[fsc_pkg::DriveW-1:0];
    end
  end

  // Result word.
  assign out_chan.valid           = s4_valid_r;
  assign out_chan.feed_drive      = s4_drive_r;
  assign out_chan.feed_reference  = s4_info_r.feed_reference;
  assign out_chan.gate_pulse      = s4_info_r.gate_pulse;
  assign out_chan.left_wheel_pwm  = s4_info_r.left_wheel_pwm;
  assign out_chan.right_wheel_pwm = s4_info_r.right_wheel_pwm;
  assign out_chan.jammed          = s4_info_r.jammed;
  assign out_chan.firing          = s4_info_r.firing;

endmodule
